FILE: design/slist_pkg.sv
`timescale 1ns / 1ps
// slist_pkg: shared types and constants of the sorted list block
// no dependencies; used by every module in design/
package slist_pkg;

	localparam int CAPACITY = 64;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_SEARCH = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	typedef struct packed {
		opcode_t                    opcode;
		logic signed [VALUE_W-1:0] value;
	} in_word_t;

	typedef struct packed {
		status_t              status;
		logic [POS_W-1:0]     position;
		logic [COUNT_W-1:0]   count;
	} out_word_t;

	// broadcast to every cell
	typedef struct packed {
		logic                       ins;
		logic                       rem;
		logic signed [VALUE_W-1:0] value;
	} cell_ctrl_t;

endpackage

FILE: design/slist_cell.sv
`timescale 1ns / 1ps
// slist_cell: one slot of the sorted chain, holds a value and shifts with neighbors
// depends on slist_pkg
module slist_cell (
	input  logic                                clk,
	input  slist_pkg::cell_ctrl_t               ctrl,
	input  logic                                occupied,
	input  logic                                prev_lt,
	input  logic signed [slist_pkg::VALUE_W-1:0] prev_value,
	input  logic signed [slist_pkg::VALUE_W-1:0] next_value,
	output logic signed [slist_pkg::VALUE_W-1:0] value_q,
	output logic                                lt,
	output logic                                eq
);

	// stored value strictly below the operand
	assign lt = occupied && (value_q < ctrl.value);
	assign eq = occupied && (value_q == ctrl.value);

	always_ff @(posedge clk) begin
		if (ctrl.ins && !lt) begin
			// insertion point takes the operand, cells behind it shift up
			if (prev_lt) begin
				value_q <= ctrl.value;
			end else begin
				value_q <= prev_value;
			end
		end else if (ctrl.rem && !lt) begin
			value_q <= next_value;
		end
	end

endmodule

FILE: design/slist_encode.sv
`timescale 1ns / 1ps
// slist_encode: reduces the per-cell compare flags to found and first-match index
// depends on slist_pkg
module slist_encode #(
	parameter int CAPACITY = slist_pkg::CAPACITY,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic [CAPACITY-1:0] lt,
	input  logic [CAPACITY-1:0] eq,
	output logic                found,
	output logic [IDX_W-1:0]    index
);

	// lt is a thermometer over the sorted cells; its edge is the first slot not below
	always_comb begin
		index = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!lt[i] && (i == 0 || lt[(i == 0) ? 0 : i - 1])) begin
				index = index | IDX_W'(i);
			end
		end
	end

	assign found = |eq;

endmodule

FILE: design/sorted_list_insert_remove_search.sv
`timescale 1ns / 1ps
// sorted_list_insert_remove_search: sorted table of signed words in a chain of cells
// a word's result is registered in the output register as the word is accepted
// one word per cycle while out_ready is high; every cell compares and shifts at once
// reset: arst_n empties the table (count 0) and drops out_valid
// stored values are not cleared; slots above the count never affect a result
// depends on slist_pkg, slist_cell, slist_encode
module sorted_list_insert_remove_search #(
	parameter int CAPACITY = slist_pkg::CAPACITY
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  slist_pkg::in_word_t  in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output slist_pkg::out_word_t out_data
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	// wide enough for both the internal and the reported widths
	localparam int PW_W  = (IDX_W > slist_pkg::POS_W) ? IDX_W : slist_pkg::POS_W;
	localparam int CW_W  = (CNT_W > slist_pkg::COUNT_W) ? CNT_W : slist_pkg::COUNT_W;

	logic [CNT_W-1:0]                    count_q;
	logic                                out_valid_q;
	slist_pkg::out_word_t                out_word_q;

	logic                                accept;
	logic                                full;
	logic                                found;
	logic [IDX_W-1:0]                    index;
	logic [CAPACITY-1:0]                 lt;
	logic [CAPACITY-1:0]                 eq;
	logic [CAPACITY-1:0]                 occupied;
	logic signed [slist_pkg::VALUE_W-1:0] cell_value [CAPACITY];
	slist_pkg::cell_ctrl_t               ctrl;

	logic [CNT_W-1:0]                    count_next;
	slist_pkg::status_t                  status_next;
	logic [IDX_W-1:0]                    pos_next;
	logic [PW_W-1:0]                     pos_wide;
	logic [CW_W-1:0]                     count_wide;

	// output register parts the two sides; a new word enters while the old one drains
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	assign full = (count_q == CNT_W'(CAPACITY));

	// operand and shift commands go to every cell at once
	always_comb begin
		ctrl.value = in_data.value;
		ctrl.ins   = accept && (in_data.opcode == slist_pkg::OP_INSERT) && !full;
		ctrl.rem   = accept && (in_data.opcode == slist_pkg::OP_REMOVE) && found;
	end

	// the chain: each cell looks at its lower and upper neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                                c_prev_lt;
		logic signed [slist_pkg::VALUE_W-1:0] c_prev_value;
		logic signed [slist_pkg::VALUE_W-1:0] c_next_value;

		assign occupied[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			// head cell: nothing below, so it is the insertion point when not below
			assign c_prev_lt    = 1'b1;
			assign c_prev_value = in_data.value;
		end else begin : g_body
			assign c_prev_lt    = lt[i-1];
			assign c_prev_value = cell_value[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			// tail keeps its value on remove; it lies above the new count anyway
			assign c_next_value = cell_value[i];
		end else begin : g_mid
			assign c_next_value = cell_value[i+1];
		end

		slist_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.occupied   (occupied[i]),
			.prev_lt    (c_prev_lt),
			.prev_value (c_prev_value),
			.next_value (c_next_value),
			.value_q    (cell_value[i]),
			.lt         (lt[i]),
			.eq         (eq[i])
		);
	end

	// sorted order makes the first equal slot the edge of the below-operand run
	slist_encode #(
		.CAPACITY (CAPACITY)
	) u_encode (
		.lt    (lt),
		.eq    (eq),
		.found (found),
		.index (index)
	);

	// result and new count
	always_comb begin
		count_next  = count_q;
		status_next = slist_pkg::ST_DONE;
		pos_next    = '0;
		case (in_data.opcode)
			slist_pkg::OP_INSERT: begin
				if (full) begin
					status_next = slist_pkg::ST_FULL;
				end else begin
					count_next = count_q + CNT_W'(1);
				end
			end
			slist_pkg::OP_REMOVE: begin
				if (found) begin
					count_next = count_q - CNT_W'(1);
				end else begin
					status_next = slist_pkg::ST_NOT_FOUND;
				end
			end
			slist_pkg::OP_SEARCH: begin
				if (found) begin
					pos_next = index;
				end else begin
					status_next = slist_pkg::ST_NOT_FOUND;
				end
			end
			slist_pkg::OP_CLEAR: begin
				count_next = '0;
			end
			default: begin
				count_next = count_q;
			end
		endcase
		// report the low bits of index and count
		pos_wide   = PW_W'(pos_next);
		count_wide = CW_W'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_word_q.status   <= status_next;
			out_word_q.position <= pos_wide[slist_pkg::POS_W-1:0];
			out_word_q.count    <= count_wide[slist_pkg::COUNT_W-1:0];
		end
	end

endmodule
